>>> sv/esc_pkg.sv
// shared types, codes and constants of the energy-scan backoff engine
package esc_pkg;

  // backoff modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_FAIR   = 2'd2;
  localparam logic [1:0] MODE_NOW    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPREAD    = 3'd5;

  // register reset values
  localparam logic [1:0]  MODE_RST      = MODE_OFF;
  localparam logic [7:0]  THRESHOLD_RST = 8'd80;
  localparam logic [15:0] WINDOW_RST    = 16'd16;
  localparam logic [7:0]  MAX_RST       = 8'd32;
  localparam logic [15:0] SCALE_RST     = 16'd1000;
  localparam logic [7:0]  SPREAD_RST    = 8'd10;

  // fixed constants of the count loading
  localparam logic [7:0]  COUNT_LIMIT  = 8'hF0;
  localparam logic [6:0]  FAIR_PERCENT = 7'd100;
  localparam int unsigned DIV_WIDTH    = 16;

  // tally width default
  localparam int unsigned TALLY_WIDTH_DEF = 16;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // divider operand selection
  localparam logic [1:0] DIV_SEL_WINDOW = 2'd0;
  localparam logic [1:0] DIV_SEL_FAIR   = 2'd1;
  localparam logic [1:0] DIV_SEL_SPREAD = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       div_start;
    logic [1:0] div_sel;
    logic       latch_quo;
    logic       commit;
  } esc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic send_window;
    logic send_fair;
    logic div_done;
    logic out_free;
  } esc_stat_t;

endpackage

>>> sv/esc_div.sv
// iterative restoring divider, one quotient bit per cycle
module esc_div
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_WIDTH-1:0] dividend,
  input  logic [DIV_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [DIV_WIDTH-1:0] quotient,
  output logic [DIV_WIDTH-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DIV_WIDTH + 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_WIDTH-1:0] dvsr;
  logic [DIV_WIDTH:0]   shifted;
  logic [DIV_WIDTH+1:0] diff;

  // trial subtract of the shifted partial remainder
  // a zero divisor always subtracts: all-ones quotient, dividend as remainder
  assign shifted = {remainder, quotient[DIV_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr};

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_WIDTH);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (running) begin
      if (!diff[DIV_WIDTH+1]) begin
        remainder <= diff[DIV_WIDTH-1:0];
        quotient  <= {quotient[DIV_WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[DIV_WIDTH-1:0];
        quotient  <= {quotient[DIV_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/esc_dp.sv
// datapath: configuration, item capture, count loading, tallies and result register
module esc_dp
  import esc_pkg::*;
#(
  parameter int unsigned TALLY_WIDTH = TALLY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_func,
  input  logic [IN_DATA_W-1:0]   in_data,
  input  esc_cmd_t               cmd,
  output esc_stat_t              stat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  // configuration registers
  logic [1:0]  backoff_mode;
  logic [7:0]  busy_threshold;
  logic [15:0] contention_window;
  logic [7:0]  backoff_cap;
  logic [15:0] fair_share_scale;
  logic [7:0]  random_spread;

  // captured item
  logic        item_func;
  logic [14:0] item_random;
  logic [15:0] item_weight;
  logic [7:0]  item_energy;
  logic        item_pending;

  // state
  logic [7:0]             backoff_count;
  logic [TALLY_WIDTH-1:0] free_total;
  logic [TALLY_WIDTH-1:0] busy_total;
  logic [15:0]            quo;

  // divider hookup
  logic [15:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [15:0] div_quo;
  logic [15:0] div_rem;
  logic [22:0] fair_product;

  // result logic
  logic [15:0]            draw;
  logic [15:0]            clipped;
  logic [7:0]             loaded;
  logic                   busy;
  logic                   step_down;
  logic [7:0]             backoff_count_next;
  logic [TALLY_WIDTH-1:0] free_total_next;
  logic [TALLY_WIDTH-1:0] busy_total_next;
  logic                   tx;
  logic                   scan;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_mode      <= MODE_RST;
      busy_threshold    <= THRESHOLD_RST;
      contention_window <= WINDOW_RST;
      backoff_cap       <= MAX_RST;
      fair_share_scale  <= SCALE_RST;
      random_spread     <= SPREAD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:      backoff_mode      <= cfg_data[1:0];
        REG_THRESHOLD: busy_threshold    <= cfg_data[7:0];
        REG_WINDOW:    contention_window <= cfg_data;
        REG_MAX:       backoff_cap       <= cfg_data[7:0];
        REG_SCALE:     fair_share_scale  <= cfg_data;
        REG_SPREAD:    random_spread     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func    <= in_func;
      item_random  <= in_data[14:0];
      item_weight  <= in_data[30:15];
      item_energy  <= in_data[38:31];
      item_pending <= in_data[39];
    end
  end

  // divider operands
  assign fair_product = {7'd0, fair_share_scale} * {16'd0, FAIR_PERCENT};

  always_comb begin
    div_dividend = {1'b0, item_random};
    div_divisor  = contention_window;
    case (cmd.div_sel)
      DIV_SEL_FAIR: begin
        div_dividend = fair_product[15:0];
        div_divisor  = item_weight;
      end
      DIV_SEL_SPREAD: div_divisor = {8'd0, random_spread};
      default: ;
    endcase
  end

  esc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // fair-share quotient kept while the offset remainder is worked out
  always_ff @(posedge clk) begin
    if (cmd.latch_quo) begin
      quo <= div_quo;
    end
  end

  // status towards the controller
  assign stat.send_window = !item_func && (backoff_mode == MODE_WINDOW);
  assign stat.send_fair   = !item_func && (backoff_mode == MODE_FAIR);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !m_tvalid || m_tready;

  // loaded count, bounded and capped
  always_comb begin
    if (backoff_mode == MODE_WINDOW) begin
      draw = div_rem + 16'd1;
    end else begin
      draw = quo + div_rem - ({8'd0, random_spread} >> 1);
    end
    if (draw == 16'd0 || draw > {8'd0, COUNT_LIMIT}) begin
      clipped = 16'd1;
    end else begin
      clipped = draw;
    end
    if (clipped >= {8'd0, backoff_cap}) begin
      loaded = backoff_cap;
    end else begin
      loaded = clipped[7:0];
    end
  end

  // outcome of the item
  assign busy      = item_energy < busy_threshold;
  assign step_down = !busy && (backoff_count != 8'd0);

  always_comb begin
    backoff_count_next = backoff_count;
    free_total_next    = free_total;
    busy_total_next    = busy_total;
    tx                 = 1'b0;
    scan               = 1'b0;
    if (item_func) begin
      if (busy) begin
        busy_total_next = busy_total + 1'b1;
      end else begin
        free_total_next = free_total + 1'b1;
      end
      if (step_down) begin
        backoff_count_next = backoff_count - 8'd1;
      end
      tx   = step_down && (backoff_count == 8'd1) && item_pending;
      scan = backoff_count_next != 8'd0;
    end else if (backoff_mode == MODE_WINDOW || backoff_mode == MODE_FAIR) begin
      backoff_count_next = loaded;
      scan               = 1'b1;
    end else begin
      tx = item_pending;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_count <= 8'd1;
      free_total    <= '0;
      busy_total    <= '0;
    end else if (cmd.commit) begin
      backoff_count <= backoff_count_next;
      free_total    <= free_total_next;
      busy_total    <= busy_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {6'd0, 16'(busy_total_next), 16'(free_total_next),
                  backoff_count_next, scan, tx};
    end
  end

  // a committed item is offered at once
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> m_tvalid)
    else $error("committed item not offered");

  // a free scan steps a running count down by one
  assert property (@(posedge clk) disable iff (rst)
      cmd.commit && item_func && step_down |=> backoff_count == $past(backoff_count) - 8'd1)
    else $error("backoff count did not step down");

  // the count never leaves its bounded range
  assert property (@(posedge clk) disable iff (rst) backoff_count <= COUNT_LIMIT)
    else $error("backoff count out of range");

  // a commit never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

endmodule

>>> sv/esc_ctrl.sv
// controller: sequences capture, divisions and commit of one item
module esc_ctrl
  import esc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  esc_stat_t stat,
  output esc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV_Q = 3'd2;
  localparam logic [2:0] S_DIV_R = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_SEL_WINDOW;
    cmd.latch_quo = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.send_window) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_WINDOW;
          state_next    = S_DIV_R;
        end else if (stat.send_fair) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_FAIR;
          state_next    = S_DIV_Q;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV_Q: begin
        if (stat.div_done) begin
          cmd.latch_quo = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_SPREAD;
          state_next    = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/energy_scan_csma_backoff.sv
// top level of the carrier-sense backoff engine with energy detection
// One item is taken at a time: s_tready is high only while the engine is idle,
// and a finished result waits in the output register while the next item is
// already accepted. A scan result, or a send request with backoff disabled or
// in immediate mode, goes from acceptance through the load and finish states
// to the result register. A send request in random window mode or adaptive
// fair-share mode waits in addition for the shared 16-bit restoring divider,
// one quotient bit per cycle, which forms the window remainder, or the
// fair-share quotient followed by the spread remainder.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// made only while no item is in flight.
module energy_scan_csma_backoff
  import esc_pkg::*;
#(
  parameter int unsigned TALLY_WIDTH = TALLY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,  // random_value, total_weight, energy_level, packet_pending
  input  logic                   s_tuser,  // func
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata   // transmit_now, scan_request, backoff_left, free_scans, busy_scans, zero pad
);

  esc_cmd_t  cmd;
  esc_stat_t stat;

  assign cfg_ready = 1'b1;

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  esc_dp #(
    .TALLY_WIDTH (TALLY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
